### hw/rtl/dhh_pkg.sv
package dhh_pkg;

   // Pixel and register widths
   localparam int PIX_W = 8;
   localparam int DISP_W = 8;
   localparam int LEN_W = 11;
   localparam int CSR_W = 11;
   localparam int CSR_IDX_W = 1;

   // Storage sizing
   localparam int MAX_DISPLACEMENT = 256;
   localparam int MAX_LINE = 1024;
   localparam int PAIR_COUNT_BITS = 20;
   localparam int ADDR_W = $clog2(MAX_DISPLACEMENT);
   localparam int POS_W = $clog2(MAX_LINE);

   // Fixed point: weights and result are Q1.16
   localparam int WEIGHT_W = 17;
   localparam int ONE_Q = 65536;
   localparam int CNT_W = PAIR_COUNT_BITS + 1;
   localparam int SUM_W = PAIR_COUNT_BITS + WEIGHT_W;
   localparam int SQ_W = 2 * PIX_W;

   // Shared restoring divider: quotient always below 2^QUOT_W
   localparam int QUOT_W = 17;
   localparam int NUM_W = SUM_W + 1;
   localparam int DEN_W = CNT_W + 1;
   localparam int STEP_W = $clog2(QUOT_W);
   localparam int WEIGHT_NUM_BASE = 2 * ONE_Q;

   // Result channel packing
   localparam int RSP_DATA_W = ((WEIGHT_W + CNT_W + 7) / 8) * 8;

   // Reset values of the registers
   localparam logic [DISP_W-1:0] DISP_RESET = DISP_W'(1);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DISPLACEMENT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LINE_LENGTH = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WDIV,
      ST_WADD,
      ST_FLOAD,
      ST_FDIV,
      ST_FOUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_load_weight;
      logic div_load_final;
      logic div_step;
      logic add_weight;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pair_ok;
      logic last;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/dhh_ram.sv
module dhh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dhh_ctrl.sv
module dhh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dhh_pkg::dp_status_type status,
   output dhh_pkg::ctrl_cmd_type  cmd
);

   dhh_pkg::state_type state_ff;
   dhh_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         dhh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = dhh_pkg::ST_READ;
            end
         end
         dhh_pkg::ST_READ: begin
            // earlier pixel of the pair is out of the store now
            if (status.pair_ok) begin
               cmd.div_load_weight = 1'b1;
               state_in = dhh_pkg::ST_WDIV;
            end else if (status.last) begin
               state_in = dhh_pkg::ST_FLOAD;
            end else begin
               state_in = dhh_pkg::ST_IDLE;
            end
         end
         dhh_pkg::ST_WDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = dhh_pkg::ST_WADD;
            end
         end
         dhh_pkg::ST_WADD: begin
            cmd.add_weight = 1'b1;
            state_in = status.last ? dhh_pkg::ST_FLOAD : dhh_pkg::ST_IDLE;
         end
         dhh_pkg::ST_FLOAD: begin
            cmd.div_load_final = 1'b1;
            state_in = dhh_pkg::ST_FDIV;
         end
         dhh_pkg::ST_FDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = dhh_pkg::ST_FOUT;
            end
         end
         dhh_pkg::ST_FOUT: begin
            // wait for the output register to drain
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = dhh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dhh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/dhh_datapath.sv
module dhh_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dhh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dhh_pkg::CSR_W-1:0]           csr_wdata,
   input  logic [dhh_pkg::PIX_W-1:0]           pixel,
   input  logic                                last_pixel,
   input  dhh_pkg::ctrl_cmd_type               cmd,
   output dhh_pkg::dp_status_type              status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [dhh_pkg::WEIGHT_W-1:0]        homogeneity,
   output logic [dhh_pkg::CNT_W-1:0]           pair_total,
   output logic                                no_pairs
);

   // Configuration registers
   logic [dhh_pkg::DISP_W-1:0] disp_ff;
   logic [dhh_pkg::LEN_W-1:0]  len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff <= dhh_pkg::DISP_RESET;
         len_ff <= dhh_pkg::LEN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dhh_pkg::REG_DISPLACEMENT: disp_ff <= csr_wdata[dhh_pkg::DISP_W-1:0];
            dhh_pkg::REG_LINE_LENGTH:  len_ff <= csr_wdata[dhh_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective displacement and line length
   logic [dhh_pkg::DISP_W-1:0] eff_disp;
   logic [dhh_pkg::LEN_W-1:0]  eff_len;

   always_comb begin
      if (disp_ff == '0) begin
         eff_disp = dhh_pkg::DISP_W'(1);
      end else if (int'(disp_ff) > dhh_pkg::MAX_DISPLACEMENT - 1) begin
         eff_disp = dhh_pkg::DISP_W'(dhh_pkg::MAX_DISPLACEMENT - 1);
      end else begin
         eff_disp = disp_ff;
      end
      if (len_ff == '0) begin
         eff_len = dhh_pkg::LEN_W'(1);
      end else if (int'(len_ff) > dhh_pkg::MAX_LINE) begin
         eff_len = dhh_pkg::LEN_W'(dhh_pkg::MAX_LINE);
      end else begin
         eff_len = len_ff;
      end
   end

   // Line position and store addressing
   logic [dhh_pkg::POS_W-1:0]  pos_ff;
   logic [dhh_pkg::POS_W-1:0]  pos_use;
   logic [dhh_pkg::LEN_W-1:0]  pos_inc;
   logic [dhh_pkg::POS_W-1:0]  pos_in;
   logic                       pair_now;
   logic [dhh_pkg::ADDR_W-1:0] wr_addr;
   logic [dhh_pkg::ADDR_W-1:0] rd_addr;

   always_comb begin
      // a position at or past the length starts a new line
      pos_use = (dhh_pkg::LEN_W'(pos_ff) >= eff_len) ? '0 : pos_ff;
      pos_inc = dhh_pkg::LEN_W'(pos_use) + dhh_pkg::LEN_W'(1);
      if (last_pixel || pos_inc >= eff_len) begin
         pos_in = '0;
      end else begin
         pos_in = pos_inc[dhh_pkg::POS_W-1:0];
      end
      pair_now = dhh_pkg::LEN_W'(pos_use) >= dhh_pkg::LEN_W'(eff_disp);
      wr_addr = pos_use[dhh_pkg::ADDR_W-1:0];
      rd_addr = dhh_pkg::ADDR_W'(pos_use - dhh_pkg::POS_W'(eff_disp));
   end

   // Captured item
   logic [dhh_pkg::PIX_W-1:0] pix_ff;
   logic                      last_ff;
   logic                      pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= pixel;
         last_ff <= last_pixel;
         pair_ff <= pair_now;
      end
   end

   // Ring of recent pixels
   logic [dhh_pkg::PIX_W-1:0] prev_pix;

   dhh_ram #(
      .WIDTH(dhh_pkg::PIX_W),
      .DEPTH(dhh_pkg::MAX_DISPLACEMENT)
   ) u_delay_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_addr),
      .wr_data (pixel),
      .rd_addr (rd_addr),
      .rd_data (prev_pix)
   );

   // Pair difference squared plus one
   logic [dhh_pkg::PIX_W-1:0] diff;
   logic [dhh_pkg::SQ_W-1:0]  q_val;

   always_comb begin
      diff = (prev_pix > pix_ff) ? prev_pix - pix_ff : pix_ff - prev_pix;
      q_val = dhh_pkg::SQ_W'(diff * diff) + dhh_pkg::SQ_W'(1);
   end

   // Accumulators
   logic [dhh_pkg::SUM_W-1:0] sum_ff;
   logic [dhh_pkg::CNT_W-1:0] count_ff;
   logic [dhh_pkg::QUOT_W-1:0] quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.div_load_final) begin
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.add_weight) begin
         sum_ff <= sum_ff + dhh_pkg::SUM_W'(quo_ff);
         count_ff <= count_ff + dhh_pkg::CNT_W'(1);
      end
   end

   // Shared divider: (2a + b) / 2b, one quotient bit a cycle
   logic [dhh_pkg::NUM_W-1:0]  div_num;
   logic [dhh_pkg::DEN_W-1:0]  div_den;
   logic [dhh_pkg::DEN_W-1:0]  rem_ff;
   logic [dhh_pkg::QUOT_W-1:0] low_ff;
   logic [dhh_pkg::DEN_W-1:0]  den_ff;
   logic [dhh_pkg::STEP_W-1:0] step_ff;
   logic [dhh_pkg::DEN_W:0]    trial;
   logic [dhh_pkg::DEN_W:0]    trial_sub;
   logic                       fits;

   always_comb begin
      if (cmd.div_load_final) begin
         div_num = {sum_ff, 1'b0} + dhh_pkg::NUM_W'(count_ff);
         div_den = {count_ff, 1'b0};
      end else begin
         div_num = dhh_pkg::NUM_W'(dhh_pkg::WEIGHT_NUM_BASE) + dhh_pkg::NUM_W'(q_val);
         div_den = dhh_pkg::DEN_W'({q_val, 1'b0});
      end
      trial = {rem_ff, low_ff[dhh_pkg::QUOT_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load_weight || cmd.div_load_final) begin
         rem_ff <= dhh_pkg::DEN_W'(div_num >> dhh_pkg::QUOT_W);
         low_ff <= div_num[dhh_pkg::QUOT_W-1:0];
         den_ff <= div_den;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? trial_sub[dhh_pkg::DEN_W-1:0] : trial[dhh_pkg::DEN_W-1:0];
         low_ff <= {low_ff[dhh_pkg::QUOT_W-2:0], 1'b0};
         quo_ff <= {quo_ff[dhh_pkg::QUOT_W-2:0], fits};
         step_ff <= step_ff + dhh_pkg::STEP_W'(1);
      end
   end

   // Image totals held while the final division runs
   logic [dhh_pkg::CNT_W-1:0] res_count_ff;
   logic                      res_zero_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load_final) begin
         res_count_ff <= count_ff;
         res_zero_ff <= (count_ff == '0);
      end
   end

   // Output register
   logic                         rsp_valid_ff;
   logic [dhh_pkg::WEIGHT_W-1:0] homog_ff;
   logic [dhh_pkg::CNT_W-1:0]    total_ff;
   logic                         no_pairs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         homog_ff <= res_zero_ff ? '0 : dhh_pkg::WEIGHT_W'(quo_ff);
         total_ff <= res_zero_ff ? '0 : res_count_ff;
         no_pairs_ff <= res_zero_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign homogeneity = homog_ff;
   assign pair_total = total_ff;
   assign no_pairs = no_pairs_ff;

   // Status to the controller
   always_comb begin
      status.pair_ok = pair_ff & ~count_ff[dhh_pkg::CNT_W-1];
      status.last = last_ff;
      status.div_last = (step_ff == dhh_pkg::STEP_W'(dhh_pkg::QUOT_W - 1));
      status.out_free = ~rsp_valid_ff | rsp_ready;
   end

endmodule

### hw/rtl/difference_histogram_homogeneity.sv
// Difference-histogram homogeneity of a grey image.
// req channel: one 8-bit pixel per item in line scan order (columns in
// column-major order for the vertical case); req_tlast marks the last
// pixel of the image. Each pixel pairs with the one "displacement"
// positions earlier on the same line; the pair adds 1/(1+diff^2) in Q1.16.
// csr port: index 0 = displacement, index 1 = line_length, to be written
// only while the block is idle; the user must keep to this, the block does not enforce it.
// rsp channel: one item per image, the mean weight in Q1.16 with the
// pair count; tuser flags an image without pairs (result zero).
// A new pixel is taken only once the previous one is done; a pixel with a
// pair waits for the 17-step radix-2 divider that forms its weight.
// The last pixel also runs the final division on the same divider
// before the result is loaded into the output register.
// Reset clears position and sums and sets the registers to their reset values;
// the pixel store needs no clearing. A stalled rsp holds its item; the next image
// is taken while it waits, and only its final result waits for the register to drain.
module difference_histogram_homogeneity (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [dhh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dhh_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dhh_pkg::PIX_W-1:0]         req_tdata,  // pixel
   input  logic                              req_tlast,  // last_pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dhh_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // homogeneity, pair_total, zero pad
   output logic                              rsp_tuser   // no_pairs
);

   dhh_pkg::ctrl_cmd_type        cmd;
   dhh_pkg::dp_status_type       status;
   logic [dhh_pkg::WEIGHT_W-1:0] homogeneity;
   logic [dhh_pkg::CNT_W-1:0]    pair_total;

   dhh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   dhh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pixel       (req_tdata),
      .last_pixel  (req_tlast),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .homogeneity (homogeneity),
      .pair_total  (pair_total),
      .no_pairs    (rsp_tuser)
   );

   assign rsp_tdata = dhh_pkg::RSP_DATA_W'({pair_total, homogeneity});

   // One item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   // Result loads only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending item");

   // An image without pairs reports zeros
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty image result is not zero");

   // Mean weight never exceeds 1.0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(homogeneity) <= dhh_pkg::ONE_Q))
      else $error("homogeneity above one");

endmodule
